// ===== rtl/tss_pkg.sv =====
package tss_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int EXT_W     = CNT_W + 1;
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 6;
   localparam int SUM_W     = VALUE_W + 2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] item_value;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] first_value;
      logic signed [VALUE_W-1:0] second_value;
      logic signed [VALUE_W-1:0] third_value;
      logic [INDEX_W-1:0]        first_index;
      logic [INDEX_W-1:0]        second_index;
      logic [INDEX_W-1:0]        third_index;
      logic                      overflowed;
   } rsp_type;

   // Reported indices are the store address masked to the output width.
   function automatic logic [INDEX_W-1:0] to_index(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W+INDEX_W-1:0] wide;
      wide = {{INDEX_W{1'b0}}, addr};
      return wide[INDEX_W-1:0];
   endfunction

   function automatic logic [EXT_W-1:0] addr_ext(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W+EXT_W-1:0] wide;
      wide = {{EXT_W{1'b0}}, addr};
      return wide[EXT_W-1:0];
   endfunction

endpackage

// ===== rtl/tss_ram.sv =====
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/triplet_sum_search_unit.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  tss_pkg::req_type (item_value, last_item)
// rsp_      out        rsp_valid/rsp_stall  tss_pkg::rsp_type (found, values, indices)
// csr_      in         csr_valid/csr_ready  target_sum, 32 bits signed
//
// Loading takes a request whenever one is valid; the last request starts the search, which reads
// one stored value per cycle: per first index a read and a latch step, per second index a sum
// step, preceded by a read step for each but its first, a scan step per candidate third index,
// a check step for setup and a finish step to post the result. Reset is synchronous and clears count,
// flags and target, not the store. req_stall is high from the last request until the
// result has been placed in the output register.
module triplet_sum_search_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tss_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tss_pkg::rsp_type  rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_wdata
);

   import tss_pkg::*;

   localparam logic [2:0] ST_LOAD    = 3'd0;
   localparam logic [2:0] ST_CHECK   = 3'd1;
   localparam logic [2:0] ST_RD_I    = 3'd2;
   localparam logic [2:0] ST_LATCH_I = 3'd3;
   localparam logic [2:0] ST_RD_J    = 3'd4;
   localparam logic [2:0] ST_SUM     = 3'd5;
   localparam logic [2:0] ST_SCAN    = 3'd6;
   localparam logic [2:0] ST_FINISH  = 3'd7;

   localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_ITEMS);

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic signed [VALUE_W-1:0] target_ff;
   logic [ADDR_W-1:0]         i_ff, i_in;
   logic [ADDR_W-1:0]         j_ff, j_in;
   logic [ADDR_W-1:0]         k_ff, k_in;
   logic signed [VALUE_W-1:0] vi_ff, vi_in;
   logic signed [VALUE_W-1:0] vj_ff, vj_in;
   logic signed [VALUE_W-1:0] vk_ff, vk_in;
   logic signed [SUM_W-1:0]   pair_ff, pair_in;
   logic                      found_ff, found_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      req_accept;
   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [VALUE_W-1:0]        ram_rd_data;
   logic signed [SUM_W-1:0]   triple_sum;
   logic                      hit;
   logic [EXT_W-1:0]          count_ext;
   logic                      last_k;
   logic                      more_j;
   logic                      more_i;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign ram_wr_en  = req_accept && (count_ff < MaxCount);
   assign csr_ready  = 1'b1;

   tss_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_ITEMS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(req_payload.item_value),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign count_ext  = {1'b0, count_ff};
   assign triple_sum = pair_ff + SUM_W'($signed(ram_rd_data));
   assign hit        = (triple_sum == SUM_W'(target_ff));
   assign last_k     = (addr_ext(k_ff) + EXT_W'(1)) == count_ext;
   assign more_j     = (addr_ext(j_ff) + EXT_W'(2)) < count_ext;
   assign more_i     = (addr_ext(i_ff) + EXT_W'(3)) < count_ext;

   // The store's read is registered, so the read address is issued in the state before the one that uses the data.
   always_comb begin
      case (state_ff)
         ST_RD_I:    ram_rd_addr = i_ff;
         ST_LATCH_I: ram_rd_addr = j_ff;
         ST_RD_J:    ram_rd_addr = j_ff;
         ST_SUM:     ram_rd_addr = j_ff + 1'b1;
         ST_SCAN:    ram_rd_addr = k_ff + 1'b1;
         default:    ram_rd_addr = i_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      vi_in        = vi_ff;
      vj_in        = vj_ff;
      vk_in        = vk_ff;
      pair_in      = pair_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (count_ff < MaxCount) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.last_item) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            found_in = 1'b0;
            i_in     = '0;
            if (count_ff < CNT_W'(3)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I: begin
            j_in     = i_ff + 1'b1;
            state_in = ST_LATCH_I;
         end
         ST_LATCH_I: begin
            vi_in    = $signed(ram_rd_data);
            state_in = ST_SUM;
         end
         ST_RD_J: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            vj_in    = $signed(ram_rd_data);
            pair_in  = SUM_W'(vi_ff) + SUM_W'($signed(ram_rd_data));
            k_in     = j_ff + 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            k_in = k_ff + 1'b1;
            if (hit) begin
               found_in = 1'b1;
               vk_in    = $signed(ram_rd_data);
               k_in     = k_ff;
               state_in = ST_FINISH;
            end else if (last_k) begin
               if (more_j) begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_RD_J;
               end else if (more_i) begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_RD_I;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.overflowed   = ovf_ff;
               if (found_ff) begin
                  rsp_in.found        = 1'b1;
                  rsp_in.first_value  = vi_ff;
                  rsp_in.second_value = vj_ff;
                  rsp_in.third_value  = vk_ff;
                  rsp_in.first_index  = to_index(i_ff);
                  rsp_in.second_index = to_index(j_ff);
                  rsp_in.third_index  = to_index(k_ff);
               end
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            target_ff <= $signed(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      vi_ff   <= vi_in;
      vj_ff   <= vj_in;
      vk_ff   <= vk_in;
      pair_ff <= pair_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("item count beyond store capacity");

   a_scan_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (k_ff > j_ff) && (j_ff > i_ff))
      else $error("search indices out of order");

   a_last_starts_search : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.last_item) |=> (state_ff == ST_CHECK))
      else $error("last request did not start the search");

   a_found_ordered : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.found) |->
         (rsp_payload.first_index < rsp_payload.second_index) &&
         (rsp_payload.second_index < rsp_payload.third_index))
      else $error("reported triple indices not ascending");
`endif

endmodule
